[sv/brfrm_pkg.sv]
`default_nettype none

package brfrm_pkg;

  // default sizes handed to the top level parameters
  localparam int DEF_RING_SLOTS   = 16;
  localparam int DEF_READER_SLOTS = 8;
  localparam int DEF_DATA_BYTES   = 1048576;

  // fixed field widths
  localparam int RS_W         = 3;
  localparam int TAG_W        = 32;
  localparam int LEN_W        = 21;
  localparam int OFF_W        = 20;
  localparam int CNT_W        = 4;
  localparam int DEPTH_CFG_W  = 5;
  localparam int REGION_CFG_W = 21;
  localparam int CFG_DATA_W   = 21;
  localparam int CFG_IDX_W    = 1;

  // configuration register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_RING_DEPTH   = 1'b0;
  localparam logic [CFG_IDX_W-1:0] CFG_REGION_BYTES = 1'b1;

  // configuration reset values
  localparam logic [DEPTH_CFG_W-1:0]  RING_DEPTH_RST   = 5'd16;
  localparam logic [REGION_CFG_W-1:0] REGION_BYTES_RST = 21'd1048576;

  typedef enum logic [2:0] {
    CMD_PUT    = 3'd0,
    CMD_GET    = 3'd1,
    CMD_PEEK   = 3'd2,
    CMD_POST   = 3'd3,
    CMD_SYNC   = 3'd4,
    CMD_REMAIN = 3'd5,
    CMD_ATTACH = 3'd6,
    CMD_DETACH = 3'd7
  } command_t;

  typedef enum logic [1:0] {
    ST_OK        = 2'd0,
    ST_EMPTY     = 2'd1,
    ST_NO_READER = 2'd2,
    ST_TOO_LONG  = 2'd3
  } status_t;

  typedef struct packed {
    command_t          command;
    logic [RS_W-1:0]   reader_slot;
    logic [TAG_W-1:0]  frame_tag;
    logic [LEN_W-1:0]  frame_length;
  } request_t;

  typedef struct packed {
    status_t           status;
    logic [TAG_W-1:0]  out_tag;
    logic [OFF_W-1:0]  out_offset;
    logic [LEN_W-1:0]  out_length;
    logic [CNT_W-1:0]  out_count;
  } response_t;

  // controller to datapath
  typedef struct packed {
    logic load;
    logic mod_start;
    logic mod_tail;
    logic head_cap;
    logic tail_cap;
    logic fetch;
    logic exec;
  } dp_cmd_t;

  // datapath to controller
  typedef struct packed {
    logic mod_done;
  } dp_stat_t;

endpackage

`default_nettype wire

[sv/brfrm_mod.sv]
`default_nettype none

// restoring remainder, one dividend bit per cycle
module brfrm_mod #(
  parameter int DVD_W = 4,
  parameter int DVS_W = 5
) (
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire logic             start,
  input  wire logic [DVD_W-1:0] dividend,
  input  wire logic [DVS_W-1:0] divisor,
  output logic                  done,
  output logic [DVD_W-1:0]      remainder
);

  localparam int CNT_W = $clog2(DVD_W + 1);

  logic             running;
  logic [CNT_W-1:0] cnt;
  logic [DVD_W-1:0] dvd;
  logic [DVS_W-1:0] rem;
  logic [DVS_W:0]   trial;
  logic [DVS_W:0]   diff;
  logic [DVS_W-1:0] step_rem;

  always_comb begin
    trial = {rem, dvd[DVD_W-1]};
    diff  = trial - {1'b0, divisor};
    if (trial >= {1'b0, divisor}) begin
      step_rem = DVS_W'(diff);
    end else begin
      step_rem = DVS_W'(trial);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      running <= 1'b0;
      cnt     <= '0;
    end else if (start) begin
      running <= 1'b1;
      cnt     <= CNT_W'(DVD_W);
    end else if (running) begin
      if (cnt != '0) begin
        cnt <= cnt - 1'b1;
      end else begin
        running <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      dvd <= dividend;
      rem <= '0;
    end else if (running && cnt != '0) begin
      rem <= step_rem;
      dvd <= dvd << 1;
    end
  end

  assign done      = running && (cnt == '0);
  assign remainder = DVD_W'(rem);

endmodule

`default_nettype wire

[sv/brfrm_datapath.sv]
`default_nettype none

module brfrm_datapath #(
  parameter int RING_SLOTS   = brfrm_pkg::DEF_RING_SLOTS,
  parameter int READER_SLOTS = brfrm_pkg::DEF_READER_SLOTS,
  parameter int DATA_BYTES   = brfrm_pkg::DEF_DATA_BYTES
) (
  input  wire logic                             clk,
  input  wire logic                             rst,
  input  wire logic                             cfg_wr,
  input  wire logic [brfrm_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  wire logic [brfrm_pkg::CFG_DATA_W-1:0] cfg_data,
  input  wire brfrm_pkg::request_t              request,
  input  wire brfrm_pkg::dp_cmd_t               cmd,
  output brfrm_pkg::dp_stat_t                   stat,
  output brfrm_pkg::response_t                  response,
  output logic                                  response_strobe
);

  localparam int SLOT_W  = (RING_SLOTS > 1) ? $clog2(RING_SLOTS) : 1;
  localparam int DEPTH_W = $clog2(RING_SLOTS + 1);
  localparam int RD_W    = (READER_SLOTS > 1) ? $clog2(READER_SLOTS) : 1;
  localparam int DCMP_W  = (DEPTH_W > brfrm_pkg::DEPTH_CFG_W) ? DEPTH_W
                                                              : brfrm_pkg::DEPTH_CFG_W;
  localparam int REGION_MAX = 2 ** brfrm_pkg::REGION_CFG_W - 1;
  localparam logic [brfrm_pkg::REGION_CFG_W-1:0] REGION_CAP =
    brfrm_pkg::REGION_CFG_W'((DATA_BYTES < REGION_MAX) ? DATA_BYTES : REGION_MAX);

  typedef struct packed {
    logic [brfrm_pkg::TAG_W-1:0] tag;
    logic [brfrm_pkg::OFF_W-1:0] offset;
    logic [brfrm_pkg::LEN_W-1:0] length;
  } slot_t;

  // configuration
  logic [brfrm_pkg::DEPTH_CFG_W-1:0]  cfg_depth;
  logic [brfrm_pkg::REGION_CFG_W-1:0] cfg_region;
  logic [DCMP_W-1:0]                  depth_ext;
  logic [DEPTH_W-1:0]                 depth;
  logic [brfrm_pkg::REGION_CFG_W-1:0] region;

  // writer and reader state
  logic [SLOT_W-1:0]                 writer_slot;
  logic [brfrm_pkg::LEN_W-1:0]       writer_offset;
  logic [READER_SLOTS-1:0]           attached;
  logic [brfrm_pkg::CNT_W-1:0]       attached_count;
  logic [SLOT_W-1:0]                 rp_mem [READER_SLOTS];
  slot_t                             slot_mem [RING_SLOTS];

  // per item registers
  brfrm_pkg::request_t               req_q;
  logic [RD_W-1:0]                   rd_q;
  logic                              rs_ok_q;
  logic [SLOT_W-1:0]                 rp_rdata;
  logic [SLOT_W-1:0]                 head_q;
  logic [SLOT_W-1:0]                 tail_q;
  slot_t                             slot_rdata;
  logic                              wrap_q;
  logic                              too_long_q;

  logic                              rs_ok;
  logic [RD_W-1:0]                   rd_idx;
  logic [SLOT_W-1:0]                 mod_dividend;
  logic [SLOT_W-1:0]                 mod_rem;

  // execute stage
  logic                              att;
  logic                              empty;
  logic [DEPTH_W-1:0]                head_inc;
  logic [DEPTH_W-1:0]                tail_inc;
  logic [SLOT_W-1:0]                 head_next;
  logic [SLOT_W-1:0]                 tail_next;
  logic [DEPTH_W-1:0]                remain;
  logic [brfrm_pkg::LEN_W-1:0]       place;
  brfrm_pkg::response_t              resp_next;
  logic [brfrm_pkg::CNT_W-1:0]       count_next;
  logic                              att_set;
  logic                              att_clr;
  logic                              rp_we;
  logic [SLOT_W-1:0]                 rp_wdata;
  logic                              slot_we;

  // clamp the configured depth and region
  always_comb begin
    depth_ext = DCMP_W'(cfg_depth);
    if (depth_ext < DCMP_W'(2)) begin
      depth = DEPTH_W'(2);
    end else if (depth_ext > DCMP_W'(RING_SLOTS)) begin
      depth = DEPTH_W'(RING_SLOTS);
    end else begin
      depth = DEPTH_W'(depth_ext);
    end
    if (cfg_region == '0) begin
      region = brfrm_pkg::REGION_CFG_W'(1);
    end else if (cfg_region > REGION_CAP) begin
      region = REGION_CAP;
    end else begin
      region = cfg_region;
    end
  end

  assign rs_ok  = 32'(request.reader_slot) < READER_SLOTS;
  assign rd_idx = rs_ok ? RD_W'(request.reader_slot) : '0;

  // head and tail reduced modulo the live depth
  assign mod_dividend = cmd.mod_tail ? rp_rdata : writer_slot;

  brfrm_mod #(
    .DVD_W (SLOT_W),
    .DVS_W (DEPTH_W)
  ) u_mod (
    .clk       (clk),
    .rst       (rst),
    .start     (cmd.mod_start),
    .dividend  (mod_dividend),
    .divisor   (depth),
    .done      (stat.mod_done),
    .remainder (mod_rem)
  );

  always_comb begin
    att      = rs_ok_q && attached[rd_q];
    empty    = head_q == tail_q;
    head_inc = DEPTH_W'(head_q) + 1'b1;
    tail_inc = DEPTH_W'(tail_q) + 1'b1;
    head_next = (head_inc == depth) ? '0 : SLOT_W'(head_inc);
    tail_next = (tail_inc == depth) ? '0 : SLOT_W'(tail_inc);
    if (head_q >= tail_q) begin
      remain = DEPTH_W'(head_q) - DEPTH_W'(tail_q);
    end else begin
      remain = DEPTH_W'(head_q) + depth - DEPTH_W'(tail_q);
    end
    place = wrap_q ? '0 : writer_offset;
  end

  always_comb begin
    resp_next  = '0;
    count_next = attached_count;
    att_set    = 1'b0;
    att_clr    = 1'b0;
    rp_we      = 1'b0;
    rp_wdata   = head_q;
    slot_we    = 1'b0;
    resp_next.status = brfrm_pkg::ST_OK;
    unique case (req_q.command)
      brfrm_pkg::CMD_PUT: begin
        if (attached_count == '0) begin
          resp_next.status = brfrm_pkg::ST_NO_READER;
        end else if (too_long_q) begin
          resp_next.status = brfrm_pkg::ST_TOO_LONG;
        end else begin
          slot_we              = 1'b1;
          resp_next.out_offset = brfrm_pkg::OFF_W'(place);
          resp_next.out_length = req_q.frame_length;
        end
      end
      brfrm_pkg::CMD_ATTACH: begin
        if (rs_ok_q) begin
          if (!attached[rd_q]) begin
            att_set    = 1'b1;
            count_next = attached_count + 1'b1;
          end
          rp_we = 1'b1;
        end
      end
      brfrm_pkg::CMD_DETACH: begin
        if (att) begin
          att_clr    = 1'b1;
          count_next = attached_count - 1'b1;
        end
      end
      brfrm_pkg::CMD_GET, brfrm_pkg::CMD_PEEK: begin
        if (!att || empty) begin
          resp_next.status = brfrm_pkg::ST_EMPTY;
        end else begin
          resp_next.out_tag    = slot_rdata.tag;
          resp_next.out_offset = slot_rdata.offset;
          resp_next.out_length = slot_rdata.length;
          rp_we    = req_q.command == brfrm_pkg::CMD_GET;
          rp_wdata = tail_next;
        end
      end
      brfrm_pkg::CMD_POST: begin
        if (!att) begin
          resp_next.status = brfrm_pkg::ST_EMPTY;
        end else begin
          rp_we    = !empty;
          rp_wdata = tail_next;
        end
      end
      brfrm_pkg::CMD_SYNC: begin
        if (!att) begin
          resp_next.status = brfrm_pkg::ST_EMPTY;
        end else begin
          rp_we = 1'b1;
        end
      end
      brfrm_pkg::CMD_REMAIN: begin
        if (!att) begin
          resp_next.status = brfrm_pkg::ST_EMPTY;
        end
      end
    endcase
    // remaining count replaces the reader count on its own command
    if (req_q.command == brfrm_pkg::CMD_REMAIN) begin
      resp_next.out_count = att ? brfrm_pkg::CNT_W'(remain) : '0;
    end else begin
      resp_next.out_count = count_next;
    end
  end

  // control state
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg_depth       <= brfrm_pkg::RING_DEPTH_RST;
      cfg_region      <= brfrm_pkg::REGION_BYTES_RST;
      writer_slot     <= '0;
      writer_offset   <= '0;
      attached        <= '0;
      attached_count  <= '0;
      response_strobe <= 1'b0;
    end else begin
      if (cfg_wr) begin
        if (cfg_index == brfrm_pkg::CFG_RING_DEPTH) begin
          cfg_depth <= cfg_data[brfrm_pkg::DEPTH_CFG_W-1:0];
        end else begin
          cfg_region <= cfg_data[brfrm_pkg::REGION_CFG_W-1:0];
        end
      end
      if (cmd.exec) begin
        attached_count <= count_next;
        if (att_set) begin
          attached[rd_q] <= 1'b1;
        end
        if (att_clr) begin
          attached[rd_q] <= 1'b0;
        end
        if (slot_we) begin
          writer_slot   <= head_next;
          writer_offset <= place + req_q.frame_length;
        end
      end
      response_strobe <= cmd.exec;
    end
  end

  // per item payload
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      req_q   <= request;
      rd_q    <= rd_idx;
      rs_ok_q <= rs_ok;
    end
    if (cmd.head_cap) begin
      head_q <= mod_rem;
    end
    if (cmd.tail_cap) begin
      tail_q <= mod_rem;
    end
    if (cmd.fetch) begin
      wrap_q     <= (writer_offset >= region) ||
                    (req_q.frame_length > region - writer_offset);
      too_long_q <= req_q.frame_length > region;
    end
    if (cmd.exec) begin
      response <= resp_next;
    end
  end

  // reader position memory
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      rp_rdata <= rp_mem[rd_idx];
    end
    if (cmd.exec && rp_we) begin
      rp_mem[rd_q] <= rp_wdata;
    end
  end

  // descriptor memory
  always_ff @(posedge clk) begin
    if (cmd.fetch) begin
      slot_rdata <= slot_mem[tail_q];
    end
    if (cmd.exec && slot_we) begin
      slot_mem[head_q] <= '{tag:    req_q.frame_tag,
                            offset: brfrm_pkg::OFF_W'(place),
                            length: req_q.frame_length};
    end
  end

endmodule

`default_nettype wire

[sv/brfrm_ctrl.sv]
`default_nettype none

module brfrm_ctrl (
  input  wire logic                clk,
  input  wire logic                rst,
  input  wire logic                start,
  output logic                     busy,
  output brfrm_pkg::dp_cmd_t       cmd,
  input  wire brfrm_pkg::dp_stat_t stat
);

  typedef enum logic [2:0] {
    S_IDLE,
    S_HEAD,
    S_TAIL,
    S_FETCH,
    S_EXEC
  } state_t;

  state_t state;
  state_t state_next;

  always_comb begin
    cmd        = '0;
    state_next = state;
    unique case (state)
      S_IDLE: begin
        if (start) begin
          cmd.load      = 1'b1;
          cmd.mod_start = 1'b1;
          state_next    = S_HEAD;
        end
      end
      S_HEAD: begin
        if (stat.mod_done) begin
          cmd.head_cap  = 1'b1;
          cmd.mod_start = 1'b1;
          cmd.mod_tail  = 1'b1;
          state_next    = S_TAIL;
        end
      end
      S_TAIL: begin
        if (stat.mod_done) begin
          cmd.tail_cap = 1'b1;
          state_next   = S_FETCH;
        end
      end
      S_FETCH: begin
        cmd.fetch  = 1'b1;
        state_next = S_EXEC;
      end
      S_EXEC: begin
        cmd.exec   = 1'b1;
        state_next = S_IDLE;
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      busy  <= 1'b0;
    end else begin
      state <= state_next;
      busy  <= state_next != S_IDLE;
    end
  end

endmodule

`default_nettype wire

[sv/broadcast_frame_ring_manager_core.sv]
`default_nettype none

// channel    signals                                   transfer
// ---------  ----------------------------------------  ---------------------------------
// command    start, busy, request                      start high while busy low
// result     response_strobe, response                 strobe high one cycle, no backoff
// config     cfg_valid, cfg_ready, cfg_index, cfg_data cfg_valid and cfg_ready high
//
// one item at a time: no new start is taken until busy drops; the response strobe
//   comes in the cycle busy drops, and start may be taken in that same cycle
// the time per item is set by the shared remainder unit, run once for the writer slot
//   and once for the reader position, one bit per cycle, plus fetch and execute steps
// rst is synchronous: no readers attached, writer at slot and offset zero, config at
//   defaults; descriptor and reader position storage is not cleared
// the receiver cannot stall; start is ignored while busy, cfg_ready follows !busy
module broadcast_frame_ring_manager_core #(
  parameter int RING_SLOTS   = brfrm_pkg::DEF_RING_SLOTS,
  parameter int READER_SLOTS = brfrm_pkg::DEF_READER_SLOTS,
  parameter int DATA_BYTES   = brfrm_pkg::DEF_DATA_BYTES
) (
  input  wire logic                             clk,
  input  wire logic                             rst,
  // command side
  input  wire logic                             start,
  output logic                                  busy,
  input  wire brfrm_pkg::request_t              request,
  // result side
  output logic                                  response_strobe,
  output brfrm_pkg::response_t                  response,
  // register writes
  input  wire logic                             cfg_valid,
  output logic                                  cfg_ready,
  input  wire logic [brfrm_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  wire logic [brfrm_pkg::CFG_DATA_W-1:0] cfg_data
);

  brfrm_pkg::dp_cmd_t  cmd;
  brfrm_pkg::dp_stat_t stat;
  logic                cfg_wr;

  // registers are only written between items
  assign cfg_ready = !busy;
  assign cfg_wr    = cfg_valid && cfg_ready;

  // sequencer: accept, head reduce, tail reduce, fetch, execute
  brfrm_ctrl u_ctrl (
    .clk   (clk),
    .rst   (rst),
    .start (start),
    .busy  (busy),
    .cmd   (cmd),
    .stat  (stat)
  );

  // ring state, descriptor storage and result formation
  brfrm_datapath #(
    .RING_SLOTS   (RING_SLOTS),
    .READER_SLOTS (READER_SLOTS),
    .DATA_BYTES   (DATA_BYTES)
  ) u_datapath (
    .clk             (clk),
    .rst             (rst),
    .cfg_wr          (cfg_wr),
    .cfg_index       (cfg_index),
    .cfg_data        (cfg_data),
    .request         (request),
    .cmd             (cmd),
    .stat            (stat),
    .response        (response),
    .response_strobe (response_strobe)
  );

endmodule

`default_nettype wire

[bench/testbench.sv]
module testbench;
  import brfrm_pkg::*;

  localparam int RING_SLOTS   = DEF_RING_SLOTS;
  localparam int READER_SLOTS = DEF_READER_SLOTS;
  localparam int DATA_BYTES   = DEF_DATA_BYTES;
  localparam int PHASES       = 8;
  localparam int PHASE_ITEMS  = 85;

  typedef struct {
    request_t  req;
    response_t want;
  } script_row_t;

  // dut connections; the driven inputs are known from time zero
  logic      clk;
  logic      rst = 1'b1;
  logic      start = 1'b0;
  logic      busy;
  request_t  request = '0;
  logic      response_strobe;
  response_t response;
  logic      cfg_valid = 1'b0;
  logic      cfg_ready;
  logic [CFG_IDX_W-1:0]  cfg_index = CFG_RING_DEPTH;
  logic [CFG_DATA_W-1:0] cfg_data = '0;

  // typed-in expectation travels with the item it belongs to
  bit        hint_known = 1'b0;
  response_t hint_want = '0;

  // ring model state
  logic [DEPTH_CFG_W-1:0]  depth_reg = RING_DEPTH_RST;
  logic [REGION_CFG_W-1:0] region_reg = REGION_BYTES_RST;
  int unsigned wr_slot = 0;
  int unsigned wr_offset = 0;
  int unsigned attached_total = 0;
  int unsigned rd_pos [READER_SLOTS];
  bit          rd_on [READER_SLOTS];
  logic [TAG_W-1:0] desc_tag [RING_SLOTS];
  int unsigned desc_off [RING_SLOTS];
  int unsigned desc_len [RING_SLOTS];

  response_t   pending_replies [$];
  script_row_t script [$];
  int          commands_taken = 0;
  int          replies_seen = 0;
  int          mismatches = 0;
  int unsigned sender_idle_pct = 0;

  // per-phase register settings and sender idling; phase 6 draws its own register settings
  int unsigned depth_plan [PHASES] = '{16, 2, 0, 5, 31, 1, 0, 16};
  int unsigned region_plan [PHASES] = '{1048576, 1, 0, 100, 2097151, 4096, 0, 1048576};
  int unsigned idle_plan [PHASES] = '{0, 79, 0, 35, 79, 0, 35, 79};

  broadcast_frame_ring_manager_core uut (
    .clk             (clk),
    .rst             (rst),
    .start           (start),
    .busy            (busy),
    .request         (request),
    .response_strobe (response_strobe),
    .response        (response),
    .cfg_valid       (cfg_valid),
    .cfg_ready       (cfg_ready),
    .cfg_index       (cfg_index),
    .cfg_data        (cfg_data)
  );

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  initial begin
    #4000000;
    $display("broadcast_frame_ring_manager_core verification failed");
    $finish;
  end

  // data region size after clamping to 1..DATA_BYTES
  function automatic int unsigned region_now();
    int unsigned r;
    r = region_reg;
    if (r < 1) r = 1;
    if (r > DATA_BYTES) r = DATA_BYTES;
    return r;
  endfunction

  // expected reply for one accepted item; updates the ring model state
  function automatic response_t ring_outcome(request_t r);
    response_t   a;
    int unsigned depth, region, head, tail, len, left;
    bit          on;
    depth = depth_reg;
    if (depth < 2) depth = 2;
    if (depth > RING_SLOTS) depth = RING_SLOTS;
    region = region_now();
    head = wr_slot % depth;
    on = rd_on[r.reader_slot];
    tail = on ? rd_pos[r.reader_slot] % depth : 0;
    left = on ? (head + depth - tail) % depth : 0;
    len = r.frame_length;
    a = '0;
    case (r.command)
      CMD_PUT: begin
        // no-reader check wins over the length check
        if (attached_total == 0) begin
          a.status = ST_NO_READER;
        end else if (len > region) begin
          a.status = ST_TOO_LONG;
        end else begin
          // offset at region end is not an address, so wrap like a misfit
          if (wr_offset >= region || len > region - wr_offset) wr_offset = 0;
          desc_tag[head] = r.frame_tag;
          desc_off[head] = wr_offset;
          desc_len[head] = len;
          a.out_offset = wr_offset;
          a.out_length = len;
          wr_offset = wr_offset + len;
          wr_slot = (head + 1) % depth;
        end
      end
      CMD_ATTACH: begin
        // attaching again only resyncs the reader
        if (!on) begin
          rd_on[r.reader_slot] = 1'b1;
          attached_total++;
        end
        rd_pos[r.reader_slot] = head;
      end
      CMD_DETACH: begin
        if (on) begin
          rd_on[r.reader_slot] = 1'b0;
          attached_total--;
        end
      end
      default: begin
        if (!on) begin
          a.status = ST_EMPTY;
        end else begin
          case (r.command)
            CMD_GET, CMD_PEEK: begin
              if (head == tail) begin
                a.status = ST_EMPTY;
              end else begin
                a.out_tag = desc_tag[tail];
                a.out_offset = desc_off[tail];
                a.out_length = desc_len[tail];
                if (r.command == CMD_GET) rd_pos[r.reader_slot] = (tail + 1) % depth;
              end
            end
            CMD_POST: begin
              if (head != tail) rd_pos[r.reader_slot] = (tail + 1) % depth;
            end
            CMD_SYNC: begin
              rd_pos[r.reader_slot] = head;
            end
            default: begin
            end
          endcase
        end
      end
    endcase
    a.out_count = (r.command == CMD_REMAIN) ? left : attached_total;
    return a;
  endfunction

  function automatic request_t order(command_t c, int unsigned rs, logic [TAG_W-1:0] t,
                                     int unsigned l);
    request_t r;
    r.command = c;
    r.reader_slot = rs;
    r.frame_tag = t;
    r.frame_length = l;
    return r;
  endfunction

  function automatic response_t reply(status_t s, logic [TAG_W-1:0] t, int unsigned o,
                                      int unsigned l, int unsigned c);
    response_t a;
    a.status = s;
    a.out_tag = t;
    a.out_offset = o;
    a.out_length = l;
    a.out_count = c;
    return a;
  endfunction

  // random item, mostly aimed at attached readers with frames that fit
  function automatic request_t draw_command();
    request_t    r;
    int unsigned pick, region;
    int unsigned live [$];
    region = region_now();
    for (int i = 0; i < READER_SLOTS; i++) begin
      if (rd_on[i]) live.push_back(i);
    end
    pick = $urandom_range(99);
    if (attached_total == 0 && pick < 60) r.command = CMD_ATTACH;
    else if (pick < 30) r.command = CMD_PUT;
    else if (pick < 48) r.command = CMD_GET;
    else if (pick < 56) r.command = CMD_PEEK;
    else if (pick < 63) r.command = CMD_POST;
    else if (pick < 68) r.command = CMD_SYNC;
    else if (pick < 78) r.command = CMD_REMAIN;
    else if (pick < 88) r.command = CMD_ATTACH;
    else if (pick < 95) r.command = CMD_DETACH;
    else r.command = command_t'($urandom_range(7));
    if (live.size() != 0 && $urandom_range(99) < 80)
      r.reader_slot = live[$urandom_range(live.size() - 1)];
    else
      r.reader_slot = $urandom_range(7);
    r.frame_tag = $urandom;
    case ($urandom_range(15))
      0: r.frame_length = $urandom;
      1: r.frame_length = region;
      2: r.frame_length = region + 1;
      3: r.frame_length = 0;
      default: r.frame_length = $urandom_range(region / 3 + 1);
    endcase
    return r;
  endfunction

  // hand one item to the block; start stays high on return
  task automatic send_command(input request_t req, input bit known, input response_t want);
    if (sender_idle_pct != 0 && $urandom_range(99) < sender_idle_pct) begin
      start <= 1'b0;
      do @(posedge clk); while ($urandom_range(99) < sender_idle_pct);
    end
    start <= 1'b1;
    request <= req;
    hint_known <= known;
    hint_want <= want;
    do @(posedge clk); while (busy);
    commands_taken++;
  endtask

  task automatic wait_for_replies();
    start <= 1'b0;
    while (replies_seen != commands_taken) @(posedge clk);
  endtask

  // scoreboard: replies are checked before the item taken at the same edge is predicted
  always @(posedge clk) begin : watch
    response_t predicted, want;
    if (!rst) begin
      if (response_strobe) begin
        replies_seen++;
        if (pending_replies.size() == 0) begin
          $display("%0t: reply with nothing outstanding: st=%0d tag=%h off=%h len=%h cnt=%h",
                   $time, response.status, response.out_tag, response.out_offset,
                   response.out_length, response.out_count);
          mismatches++;
        end else begin
          want = pending_replies.pop_front();
          if (response.status !== want.status || response.out_tag !== want.out_tag ||
              response.out_offset !== want.out_offset ||
              response.out_length !== want.out_length ||
              response.out_count !== want.out_count) begin
            $display("%0t: reply mismatch, expected st=%0d tag=%h off=%h len=%h cnt=%h",
                     $time, want.status, want.out_tag, want.out_offset, want.out_length,
                     want.out_count);
            $display("%0t:                 actual   st=%0d tag=%h off=%h len=%h cnt=%h",
                     $time, response.status, response.out_tag, response.out_offset,
                     response.out_length, response.out_count);
            mismatches++;
          end
        end
      end
      if (start && !busy) begin
        predicted = ring_outcome(request);
        pending_replies.push_back(hint_known ? hint_want : predicted);
      end
    end
  end

  initial begin
    logic [CFG_DATA_W-1:0] depth_val, region_val;
    // after reset: depth 16, region 1 MiB, no readers
    script.push_back('{order(CMD_PUT, 0, 32'h0bad_f00d, 5), reply(ST_NO_READER, 0, 0, 0, 0)});
    script.push_back('{order(CMD_GET, 3, 0, 0), reply(ST_EMPTY, 0, 0, 0, 0)});
    script.push_back('{order(CMD_REMAIN, 7, 0, 0), reply(ST_EMPTY, 0, 0, 0, 0)});
    // detach of an idle slot is harmless
    script.push_back('{order(CMD_DETACH, 2, 0, 0), reply(ST_OK, 0, 0, 0, 0)});
    script.push_back('{order(CMD_ATTACH, 0, 0, 0), reply(ST_OK, 0, 0, 0, 1)});
    // peek and post on an empty ring
    script.push_back('{order(CMD_PEEK, 0, 0, 0), reply(ST_EMPTY, 0, 0, 0, 1)});
    script.push_back('{order(CMD_POST, 0, 0, 0), reply(ST_OK, 0, 0, 0, 1)});
    // zero length, then a frame filling the whole region
    script.push_back('{order(CMD_PUT, 5, 32'hffff_ffff, 0), reply(ST_OK, 0, 0, 0, 1)});
    script.push_back('{order(CMD_PUT, 0, 32'h0, 1048576), reply(ST_OK, 0, 0, 1048576, 1)});
    // running offset sits at region end, so the frame goes to zero
    script.push_back('{order(CMD_PUT, 0, 32'h1234_5678, 1), reply(ST_OK, 0, 0, 1, 1)});
    // too long, both at the field maximum and just past the region
    script.push_back('{order(CMD_PUT, 0, 0, 21'h1f_ffff), reply(ST_TOO_LONG, 0, 0, 0, 1)});
    script.push_back('{order(CMD_PUT, 0, 0, 1048577), reply(ST_TOO_LONG, 0, 0, 0, 1)});
    script.push_back('{order(CMD_ATTACH, 7, 0, 0), reply(ST_OK, 0, 0, 0, 2)});
    script.push_back('{order(CMD_REMAIN, 0, 0, 0), reply(ST_OK, 0, 0, 0, 3)});
    script.push_back('{order(CMD_PEEK, 0, 0, 0), reply(ST_OK, 32'hffff_ffff, 0, 0, 2)});
    script.push_back('{order(CMD_GET, 0, 0, 0), reply(ST_OK, 32'hffff_ffff, 0, 0, 2)});
    script.push_back('{order(CMD_GET, 0, 0, 0), reply(ST_OK, 0, 0, 1048576, 2)});
    // attaching an attached reader resyncs it to the writer
    script.push_back('{order(CMD_ATTACH, 0, 0, 0), reply(ST_OK, 0, 0, 0, 2)});
    script.push_back('{order(CMD_REMAIN, 0, 0, 0), reply(ST_OK, 0, 0, 0, 0)});
    // exact fit up to region end
    script.push_back('{order(CMD_PUT, 3, 32'ha5a5_5a5a, 1048575),
                       reply(ST_OK, 0, 1, 1048575, 2)});
    script.push_back('{order(CMD_SYNC, 7, 0, 0), reply(ST_OK, 0, 0, 0, 2)});
    script.push_back('{order(CMD_GET, 0, 0, 0), reply(ST_OK, 32'ha5a5_5a5a, 1, 1048575, 2)});
    script.push_back('{order(CMD_DETACH, 0, 0, 0), reply(ST_OK, 0, 0, 0, 1)});
    // get on a detached reader
    script.push_back('{order(CMD_GET, 0, 0, 0), reply(ST_EMPTY, 0, 0, 0, 1)});
    script.push_back('{order(CMD_DETACH, 7, 0, 0), reply(ST_OK, 0, 0, 0, 0)});

    repeat (11) @(posedge clk);
    rst <= 1'b0;

    foreach (script[i]) send_command(script[i].req, 1'b1, script[i].want);

    for (int ph = 0; ph < PHASES; ph++) begin
      sender_idle_pct = idle_plan[ph];
      // readers leave before a depth change so no one lands on a stale descriptor
      for (int rs = 0; rs < READER_SLOTS; rs++)
        send_command(order(CMD_DETACH, rs, 0, 0), 1'b0, '0);
      wait_for_replies();
      if (ph == 6) begin
        depth_val = $urandom_range(31);
        region_val = $urandom_range(1048576, 1);
      end else begin
        depth_val = depth_plan[ph];
        region_val = region_plan[ph];
      end
      // register writes only while the block is idle
      cfg_valid <= 1'b1;
      cfg_index <= CFG_RING_DEPTH;
      cfg_data <= depth_val;
      do @(posedge clk); while (!cfg_ready);
      cfg_index <= CFG_REGION_BYTES;
      cfg_data <= region_val;
      do @(posedge clk); while (!cfg_ready);
      cfg_valid <= 1'b0;
      depth_reg = depth_val[DEPTH_CFG_W-1:0];
      region_reg = region_val;
      for (int n = 0; n < PHASE_ITEMS; n++) send_command(draw_command(), 1'b0, '0);
    end

    wait_for_replies();
    repeat (30) @(posedge clk);
    if (pending_replies.size() != 0) begin
      $display("%0t: %0d replies never arrived", $time, pending_replies.size());
      mismatches++;
    end
    if (mismatches == 0) begin
      $display("broadcast_frame_ring_manager_core verification clean");
    end else begin
      $display("broadcast_frame_ring_manager_core verification failed");
    end
    $finish;
  end

endmodule
